// File: src/hrcc_pkg.sv
// ----------------------------------------------------------------------------
// hrcc_pkg: shared types and constants for the heart rate condition classifier
// Beat payloads, configuration register indexes, reset values, condition codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hrcc_pkg;

    typedef struct packed {
        logic [9:0]  pulse_rate;
        logic        walking;
        logic        running;
        logic [3:0]  posture;
        logic [9:0]  shown_pulse;
        logic [31:0] now_seconds;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  condition;
        logic [10:0] adaptive_threshold;
    } out_beat_t;

    typedef struct packed {
        logic [9:0]  tachy_base;
        logic [9:0]  hard_brady_limit;
        logic [9:0]  brady_limit;
        logic [9:0]  hard_tachy_limit;
        logic [15:0] start_window;
        logic [7:0]  start_add;
        logic [7:0]  tune_interval;
        logic [7:0]  repeat_count;
    } cfg_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_TACHY_BASE       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HARD_BRADY_LIMIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BRADY_LIMIT      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HARD_TACHY_LIMIT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_START_WINDOW     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_START_ADD        = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TUNE_INTERVAL    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_COUNT     = 3'd7;

    localparam logic [9:0]  TACHY_BASE_RST       = 10'd120;
    localparam logic [9:0]  HARD_BRADY_LIMIT_RST = 10'd40;
    localparam logic [9:0]  BRADY_LIMIT_RST      = 10'd50;
    localparam logic [9:0]  HARD_TACHY_LIMIT_RST = 10'd180;
    localparam logic [15:0] START_WINDOW_RST     = 16'd30;
    localparam logic [7:0]  START_ADD_RST        = 8'd10;
    localparam logic [7:0]  TUNE_INTERVAL_RST    = 8'd10;
    localparam logic [7:0]  REPEAT_COUNT_RST     = 8'd3;

    localparam logic [2:0] COND_NONE     = 3'd0;
    localparam logic [2:0] COND_FIT      = 3'd1;
    localparam logic [2:0] COND_LIGHT    = 3'd2;
    localparam logic [2:0] COND_HARD     = 3'd3;
    localparam logic [2:0] COND_ASYSTOLE = 3'd4;

    localparam logic [1:0] SLOPE_LOW  = 2'd1;
    localparam logic [1:0] SLOPE_MID  = 2'd2;
    localparam logic [1:0] SLOPE_HIGH = 2'd3;

    localparam logic [3:0]  LOCO_POSTURE = 4'd8;
    localparam logic [9:0]  PULSE_CEIL   = 10'd300;
    localparam logic [31:0] SLOPE_MID_LO = 32'd60;
    localparam logic [31:0] SLOPE_MID_HI = 32'd120;
    localparam logic [10:0] THR_MAX      = 11'd2047;
    localparam logic [10:0] THR_MAX_SEEN = 11'd1278;

    // floor(x / 10) == (x * 205) >> 11 for every x below 1024
    localparam logic [17:0] DIV10_RECIP = 18'd205;

endpackage

`default_nettype wire

// File: src/hrcc_regs.sv
// ----------------------------------------------------------------------------
// hrcc_regs: configuration register file
// Eight write-only limit and timing registers, loaded by index.
// ----------------------------------------------------------------------------
`default_nettype none

module hrcc_regs
    import hrcc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_TACHY_BASE:       cfg_next.tachy_base       = cfg_data[9:0];
                REG_HARD_BRADY_LIMIT: cfg_next.hard_brady_limit = cfg_data[9:0];
                REG_BRADY_LIMIT:      cfg_next.brady_limit      = cfg_data[9:0];
                REG_HARD_TACHY_LIMIT: cfg_next.hard_tachy_limit = cfg_data[9:0];
                REG_START_WINDOW:     cfg_next.start_window     = cfg_data[15:0];
                REG_START_ADD:        cfg_next.start_add        = cfg_data[7:0];
                REG_TUNE_INTERVAL:    cfg_next.tune_interval    = cfg_data[7:0];
                REG_REPEAT_COUNT:     cfg_next.repeat_count     = cfg_data[7:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tachy_base       <= TACHY_BASE_RST;
            cfg_reg.hard_brady_limit <= HARD_BRADY_LIMIT_RST;
            cfg_reg.brady_limit      <= BRADY_LIMIT_RST;
            cfg_reg.hard_tachy_limit <= HARD_TACHY_LIMIT_RST;
            cfg_reg.start_window     <= START_WINDOW_RST;
            cfg_reg.start_add        <= START_ADD_RST;
            cfg_reg.tune_interval    <= TUNE_INTERVAL_RST;
            cfg_reg.repeat_count     <= REPEAT_COUNT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: src/heart_rate_condition_classifier.sv
// ----------------------------------------------------------------------------
// heart_rate_condition_classifier: pulse condition classifier, adaptive threshold
// Tracks rest timing, relaxes the tachycardia threshold and debounces classes.
// ----------------------------------------------------------------------------
//
//   channel | signals                              | beat
//   --------+--------------------------------------+-------------------------
//   in      | in_valid, in_stall, in_data          | one pulse sample
//   out     | out_valid, out_stall, out_data       | one condition result
//   cfg     | cfg_write, cfg_index, cfg_data       | one register write
//
// One result beat per input beat. A beat waits in the input register, where the state
// update runs, and moves into the result register when it advances; one beat per
// cycle sustained while the result is not stalled.
// Reset loads the limits and sets the adaptive threshold to the base limit.
// A stalled result holds the input register, which then stalls the input.
//
`default_nettype none

module heart_rate_condition_classifier
    import hrcc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire in_beat_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output out_beat_t                   out_data,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg;

    hrcc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input stage
    logic      in_valid_reg;
    in_beat_t  in_data_reg;
    logic      advance;
    logic      in_take;

    // result stage
    logic      out_valid_reg;
    out_beat_t out_data_reg;

    // block state
    logic [10:0] thr_reg,        thr_next;
    logic [10:0] start_reg,      start_next;
    logic [31:0] rest_start_reg, rest_start_next;
    logic [31:0] last_tune_reg,  last_tune_next;
    logic        tuned_reg,      tuned_next;
    logic [1:0]  slope_reg,      slope_next;
    logic [7:0]  black_reg,      black_next;
    logic [7:0]  red_reg,        red_next;
    logic [7:0]  yellow_reg,     yellow_next;
    logic [2:0]  held_reg,       held_next;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    function automatic logic [7:0] sat_inc(input logic [7:0] c);
        sat_inc = (c == 8'hFF) ? 8'hFF : c + 8'd1;
    endfunction

    always_comb
    begin
        logic        loco;
        logic [31:0] rest;
        logic [31:0] window;
        logic [31:0] interval;
        logic [11:0] start_sum;
        logic [9:0]  prod;
        logic [17:0] scaled;
        logic [10:0] dec;
        logic [2:0]  cls;
        logic [9:0]  pulse;

        loco      = in_data_reg.walking || in_data_reg.running ||
                    (in_data_reg.posture == LOCO_POSTURE);
        rest      = in_data_reg.now_seconds - rest_start_reg;
        window    = {16'd0, cfg.start_window};
        interval  = {24'd0, cfg.tune_interval};
        start_sum = {1'b0, start_reg} + {4'd0, cfg.start_add};
        prod      = 10'd0;
        scaled    = 18'd0;
        dec       = 11'd0;
        pulse     = in_data_reg.pulse_rate;

        thr_next        = thr_reg;
        start_next      = start_reg;
        rest_start_next = rest_start_reg;
        last_tune_next  = last_tune_reg;
        tuned_next      = tuned_reg;
        slope_next      = slope_reg;

        if (loco)
        begin
            rest_start_next = in_data_reg.now_seconds;
        end
        else
        begin
            if (rest < window && thr_reg < {1'b0, in_data_reg.shown_pulse})
            begin
                thr_next   = {1'b0, in_data_reg.shown_pulse} + {3'd0, cfg.start_add};
                start_next = {1'b0, in_data_reg.shown_pulse};
                slope_next = SLOPE_LOW;
            end
            else if (rest >= window && start_reg < thr_reg)
            begin
                start_next = start_sum[11] ? THR_MAX : start_sum[10:0];
            end

            if (thr_next > {1'b0, cfg.tachy_base} &&
                (in_data_reg.now_seconds - last_tune_reg) >= interval &&
                rest > window)
            begin
                if (rest > SLOPE_MID_LO && rest < SLOPE_MID_HI)
                    slope_next = SLOPE_MID;
                else if (rest > SLOPE_MID_HI)
                    slope_next = SLOPE_HIGH;

                if (!tuned_reg)
                begin
                    // slope times interval by shift and add, then divide by ten
                    case (slope_next)
                        SLOPE_LOW:  prod = {2'd0, cfg.tune_interval};
                        SLOPE_MID:  prod = {1'b0, cfg.tune_interval, 1'b0};
                        SLOPE_HIGH: prod = {2'd0, cfg.tune_interval} +
                                           {1'b0, cfg.tune_interval, 1'b0};
                        default:    prod = 10'd0;
                    endcase
                    scaled         = {8'd0, prod} * DIV10_RECIP;
                    dec            = {4'd0, scaled[17:11]};
                    thr_next       = (thr_next > dec) ? thr_next - dec : 11'd0;
                    last_tune_next = in_data_reg.now_seconds;
                    tuned_next     = 1'b1;
                end
            end

            if (tuned_next && (in_data_reg.now_seconds - last_tune_next) >= interval)
                tuned_next = 1'b0;
        end

        if (pulse == 10'd0)
            cls = COND_ASYSTOLE;
        else if (pulse < cfg.hard_brady_limit)
            cls = COND_HARD;
        else if (pulse < cfg.brady_limit)
            cls = COND_LIGHT;
        else if (pulse < PULSE_CEIL)
        begin
            if ({1'b0, pulse} > thr_next)
                cls = (pulse > cfg.hard_tachy_limit) ? COND_HARD : COND_LIGHT;
            else
                cls = COND_FIT;
        end
        else
            cls = COND_NONE;

        black_next  = (cls == COND_ASYSTOLE) ? sat_inc(black_reg)  : 8'd0;
        red_next    = (cls == COND_HARD)     ? sat_inc(red_reg)    : 8'd0;
        yellow_next = (cls == COND_LIGHT)    ? sat_inc(yellow_reg) : 8'd0;
        held_next   = held_reg;

        if (yellow_next >= cfg.repeat_count)
        begin
            yellow_next = cfg.repeat_count;
            held_next   = COND_LIGHT;
        end
        else if (red_next >= cfg.repeat_count)
        begin
            red_next  = cfg.repeat_count;
            held_next = COND_HARD;
        end
        else if (black_next >= cfg.repeat_count)
        begin
            black_next = cfg.repeat_count;
            held_next  = COND_ASYSTOLE;
        end
        else if (cls == COND_FIT)
        begin
            held_next = COND_FIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            thr_reg        <= {1'b0, TACHY_BASE_RST};
            start_reg      <= 11'd0;
            rest_start_reg <= 32'd0;
            last_tune_reg  <= 32'd0;
            tuned_reg      <= 1'b0;
            slope_reg      <= SLOPE_LOW;
            black_reg      <= 8'd0;
            red_reg        <= 8'd0;
            yellow_reg     <= 8'd0;
            held_reg       <= COND_NONE;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                thr_reg        <= thr_next;
                start_reg      <= start_next;
                rest_start_reg <= rest_start_next;
                last_tune_reg  <= last_tune_next;
                tuned_reg      <= tuned_next;
                slope_reg      <= slope_next;
                black_reg      <= black_next;
                red_reg        <= red_next;
                yellow_reg     <= yellow_next;
                held_reg       <= held_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= in_data;
        if (advance)
        begin
            out_data_reg.condition          <= held_next;
            out_data_reg.adaptive_threshold <= thr_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    // only one class can be on a run at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones({|black_reg, |red_reg, |yellow_reg}) <= 1)
        else $error("more than one run counter active");

    // threshold comes from the reset base or from shown pulse plus margin, then decreases
    assert property (@(posedge clk) disable iff (!rst_n)
        thr_reg <= THR_MAX_SEEN)
        else $error("adaptive threshold out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        slope_reg != 2'd0)
        else $error("slope code zero");

    // a beat that leaves the input stage lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg && out_data_reg.adaptive_threshold == thr_reg)
        else $error("result register missed a beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without a blocked result");
`endif

endmodule

`default_nettype wire
